/* src/lhs_pkg.sv */
// Shared widths, constants and stage structs for the hillshade pipeline.
`timescale 1ns / 1ps
`default_nettype none

package lhs_pkg;

    localparam int H_W        = 16;  // height sample
    localparam int L_W        = 16;  // light vector component, Q1.14
    localparam int LEN_CFG_W  = 11;  // line_length register
    localparam int CNT_W      = 13;  // line_count register and line counter
    localparam int MAG_W      = 16;  // magnitude of a height difference
    localparam int SQ_W       = 32;  // square of a magnitude
    localparam int S_W        = 33;  // squared length of a normal
    localparam int R_W        = 62;  // remainder of the root search
    localparam int U_W        = 48;  // running root times squared length
    localparam int T_W        = 15;  // root bits
    localparam int TR_W       = 64;  // trial value of one root step
    localparam int FRAC_SHIFT = 30;
    localparam int M_W        = 17;  // sum of two unit components, Q2.14
    localparam int NLANE      = 6;
    localparam int FIFO_AW    = 5;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Slope vectors of one pixel: x1, y1 of the first normal, x2, y2 of the second.
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [3:0][MAG_W-1:0] mag;
        logic [3:0]            neg;
    } t_vec;

    // Sum of the two unit normals.
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic signed [M_W-1:0] mx;
        logic signed [M_W-1:0] my;
        logic signed [M_W-1:0] mz;
    } t_norm;

endpackage

`default_nettype wire

/* src/lhs_ram.sv */
// Generic simple dual-port RAM with two registered read ports, read-first.
`timescale 1ns / 1ps
`default_nettype none

module lhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

/* src/lhs_window.sv */
// Line memory, scan counters and neighbor window that forms the slope vectors.
`timescale 1ns / 1ps
`default_nettype none

module lhs_window #(
    parameter int LINE_MAX = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [lhs_pkg::H_W-1:0]        i_height,
    input  wire logic [lhs_pkg::LEN_CFG_W-1:0]  i_line_length,
    input  wire logic [lhs_pkg::CNT_W-1:0]      i_line_count,
    output logic                                o_emit,
    output lhs_pkg::t_vec                       o_vec
);

    import lhs_pkg::*;

    localparam int AW    = $clog2(LINE_MAX);
    localparam int LEN_W = (AW + 1 > LEN_CFG_W) ? AW + 1 : LEN_CFG_W;
    localparam int D_W   = H_W + 1;

    localparam logic [2:0] CL_INTERIOR = 3'd0;
    localparam logic [2:0] CL_FWD      = 3'd1;
    localparam logic [2:0] CL_BWD      = 3'd2;
    localparam logic [2:0] CL_MIX_CB   = 3'd3;
    localparam logic [2:0] CL_MIX_AD   = 3'd4;

    logic [LEN_W-1:0] len_ext, len_use, pos_inc;
    logic [CNT_W-1:0] cnt_use;
    logic [AW-1:0]    r_pos;
    logic [CNT_W-1:0] r_line;
    logic             rf, rl, lf, flush;
    logic [2:0]       cls;

    always_comb begin
        len_ext = LEN_W'(i_line_length);
        if (len_ext < LEN_W'(2)) begin
            len_use = LEN_W'(2);
        end else if (len_ext > LEN_W'(LINE_MAX)) begin
            len_use = LEN_W'(LINE_MAX);
        end else begin
            len_use = len_ext;
        end
        cnt_use = (i_line_count < CNT_W'(2)) ? CNT_W'(2) : i_line_count;
    end

    assign pos_inc = LEN_W'(r_pos) + LEN_W'(1);
    assign rf      = (r_pos == '0);
    assign rl      = (pos_inc >= len_use);
    assign flush   = (r_line >= cnt_use);
    assign lf      = (r_line == CNT_W'(1));
    assign o_emit  = (r_line != '0);

    // The output line is the previous one, so its last row is the flush line.
    always_comb begin
        if (!rf && !rl && !lf && !flush) begin
            cls = CL_INTERIOR;
        end else if (rf && flush && !lf) begin
            cls = CL_MIX_CB;
        end else if (rl && lf && !flush) begin
            cls = CL_MIX_AD;
        end else if (rf || lf) begin
            cls = CL_FWD;
        end else begin
            cls = CL_BWD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_line <= '0;
        end else if (i_accept) begin
            if (rl) begin
                r_pos  <= '0;
                r_line <= flush ? '0 : r_line + CNT_W'(1);
            end else begin
                r_pos <= pos_inc[AW-1:0];
            end
        end
    end

    // Stage 1: memory data arrives.
    logic             r1_valid, r1_emit, r1_last;
    logic [2:0]       r1_class;
    logic [H_W-1:0]   r1_h;
    logic [AW-1:0]    r1_p, r1_pb;
    logic             r2_valid;
    logic [AW-1:0]    r2_p;
    logic [H_W-1:0]   r2_h;
    logic [H_W-1:0]   r_last_ctr;
    logic [2*H_W-1:0] rd_a, rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_accept;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_emit  <= o_emit;
        r1_last  <= rl && flush;
        r1_class <= cls;
        r1_h     <= i_height;
        r1_p     <= r_pos;
        r1_pb    <= pos_inc[AW-1:0];
        r2_p     <= r1_p;
        r2_h     <= r1_h;
    end

    // Each entry holds the older line in the upper half and the last line below.
    lhs_ram #(
        .WIDTH (2 * H_W),
        .DEPTH (LINE_MAX)
    ) u_lines (
        .i_clk     (i_clk),
        .i_we      (r1_valid),
        .i_waddr   (r1_p),
        .i_wdata   ({rd_a[H_W-1:0], r1_h}),
        .i_raddr_a (r_pos),
        .i_raddr_b (pos_inc[AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    logic [H_W-1:0] ctr, older_p, np;
    logic signed [D_W-1:0] da, db, dc, dd;
    logic [MAG_W-1:0] ma, mb, mc, md;
    logic [D_W-1:0] abs_a, abs_b, abs_c, abs_d;
    logic na, nb, nc, nd;
    t_vec n_vec;

    // With two-sample lines the next sample was written in the very cycle of this read.
    assign np      = (r2_valid && (r2_p == r1_pb)) ? r2_h : rd_b[H_W-1:0];
    assign ctr     = rd_a[H_W-1:0];
    assign older_p = rd_a[2*H_W-1:H_W];

    always_comb begin
        da = $signed({ctr[H_W-1], ctr}) - $signed({r1_h[H_W-1], r1_h});
        db = $signed({ctr[H_W-1], ctr}) - $signed({np[H_W-1], np});
        dc = $signed({ctr[H_W-1], ctr}) - $signed({older_p[H_W-1], older_p});
        dd = $signed({ctr[H_W-1], ctr}) - $signed({r_last_ctr[H_W-1], r_last_ctr});
        na = da[D_W-1];
        nb = db[D_W-1];
        nc = dc[D_W-1];
        nd = dd[D_W-1];
        abs_a = na ? D_W'(-da) : D_W'(da);
        abs_b = nb ? D_W'(-db) : D_W'(db);
        abs_c = nc ? D_W'(-dc) : D_W'(dc);
        abs_d = nd ? D_W'(-dd) : D_W'(dd);
        ma = abs_a[MAG_W-1:0];
        mb = abs_b[MAG_W-1:0];
        mc = abs_c[MAG_W-1:0];
        md = abs_d[MAG_W-1:0];

        n_vec.valid = r1_valid && r1_emit;
        n_vec.last  = r1_last;
        unique case (r1_class)
            CL_INTERIOR: begin
                n_vec.mag = {md, mc, mb, ma};
                n_vec.neg = {!nd, nc, nb, !na};
            end
            CL_FWD: begin
                n_vec.mag = {mb, ma, mb, ma};
                n_vec.neg = {nb, !na, nb, !na};
            end
            CL_BWD: begin
                n_vec.mag = {md, mc, md, mc};
                n_vec.neg = {!nd, nc, !nd, nc};
            end
            CL_MIX_CB: begin
                n_vec.mag = {mb, mc, mb, mc};
                n_vec.neg = {nb, nc, nb, nc};
            end
            CL_MIX_AD: begin
                n_vec.mag = {md, ma, md, ma};
                n_vec.neg = {!nd, !na, !nd, !na};
            end
            default: begin
                n_vec.mag = {md, mc, md, mc};
                n_vec.neg = {!nd, nc, !nd, nc};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r_last_ctr <= ctr;
        end
        o_vec.last <= n_vec.last;
        o_vec.mag  <= n_vec.mag;
        o_vec.neg  <= n_vec.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vec.valid <= 1'b0;
        end else begin
            o_vec.valid <= n_vec.valid;
        end
    end

endmodule

`default_nettype wire

/* src/lhs_unit.sv */
// Pipelined normalization: squared lengths, one root bit per stage, normal sum.
`timescale 1ns / 1ps
`default_nettype none

module lhs_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lhs_pkg::t_vec  i_vec,
    output lhs_pkg::t_norm      o_norm
);

    import lhs_pkg::*;

    // Stage a: squares of the four slope magnitudes.
    logic [3:0][SQ_W-1:0] r_sq;
    logic [3:0]           r_a_neg;
    logic                 r_a_valid, r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_vec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_last <= i_vec.last;
        r_a_neg  <= i_vec.neg;
        for (int j = 0; j < 4; j++) begin
            r_sq[j] <= i_vec.mag[j] * i_vec.mag[j];
        end
    end

    // Root search state, index 0 loaded from stage a, index T_W holds the result.
    // Each lane finds the largest t with t*t*S <= v*v*2^30, which equals
    // isqrt(floor(v*v*2^30 / S)).
    logic [R_W-1:0] r_rem  [T_W+1][NLANE];
    logic [U_W-1:0] r_acc  [T_W+1][NLANE];
    logic [T_W-1:0] r_root [T_W+1][NLANE];
    logic [S_W-1:0] r_sum  [T_W+1][2];
    logic [3:0]     r_neg  [T_W+1];
    logic           r_lst  [T_W+1];
    logic           r_val  [T_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[0] <= 1'b0;
        end else begin
            r_val[0] <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lst[0]    <= r_a_last;
        r_neg[0]    <= r_a_neg;
        r_sum[0][0] <= S_W'(r_sq[0]) + S_W'(r_sq[1]) + S_W'(1);
        r_sum[0][1] <= S_W'(r_sq[2]) + S_W'(r_sq[3]) + S_W'(1);
        r_rem[0][0] <= R_W'(r_sq[0]) << FRAC_SHIFT;
        r_rem[0][1] <= R_W'(r_sq[1]) << FRAC_SHIFT;
        r_rem[0][2] <= R_W'(1) << FRAC_SHIFT;
        r_rem[0][3] <= R_W'(r_sq[2]) << FRAC_SHIFT;
        r_rem[0][4] <= R_W'(r_sq[3]) << FRAC_SHIFT;
        r_rem[0][5] <= R_W'(1) << FRAC_SHIFT;
        for (int ln = 0; ln < NLANE; ln++) begin
            r_acc[0][ln]  <= '0;
            r_root[0][ln] <= '0;
        end
    end

    for (genvar s = 0; s < T_W; s++) begin : g_step
        localparam int K = T_W - 1 - s;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[s+1] <= 1'b0;
            end else begin
                r_val[s+1] <= r_val[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_lst[s+1]    <= r_lst[s];
            r_neg[s+1]    <= r_neg[s];
            r_sum[s+1][0] <= r_sum[s][0];
            r_sum[s+1][1] <= r_sum[s][1];
        end

        for (genvar ln = 0; ln < NLANE; ln++) begin : g_lane
            localparam int NI = ln / 3;
            logic [TR_W-1:0] trial;
            logic            fits;

            // (t + 2^K)^2 * S - t^2 * S = t*S*2^(K+1) + S*2^(2K)
            assign trial = (TR_W'(r_acc[s][ln]) << (K + 1))
                         + (TR_W'(r_sum[s][NI]) << (2 * K));
            assign fits  = (TR_W'(r_rem[s][ln]) >= trial);

            always_ff @(posedge i_clk) begin
                if (fits) begin
                    r_rem[s+1][ln]  <= r_rem[s][ln] - R_W'(trial);
                    r_root[s+1][ln] <= r_root[s][ln] | (T_W'(1) << K);
                    r_acc[s+1][ln]  <= r_acc[s][ln] + (U_W'(r_sum[s][NI]) << K);
                end else begin
                    r_rem[s+1][ln]  <= r_rem[s][ln];
                    r_root[s+1][ln] <= r_root[s][ln];
                    r_acc[s+1][ln]  <= r_acc[s][ln];
                end
            end
        end
    end

    // Round half up from one extra root bit and apply the component sign.
    function automatic logic signed [M_W-1:0] unit_val(input logic [T_W-1:0] t,
                                                       input logic neg);
        logic [T_W:0] r;
        r = ({1'b0, t} + (T_W + 1)'(1)) >> 1;
        unit_val = neg ? -$signed(M_W'(r)) : $signed(M_W'(r));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_norm.valid <= 1'b0;
        end else begin
            o_norm.valid <= r_val[T_W];
        end
    end

    always_ff @(posedge i_clk) begin
        o_norm.last <= r_lst[T_W];
        o_norm.mx   <= unit_val(r_root[T_W][0], r_neg[T_W][0])
                     + unit_val(r_root[T_W][3], r_neg[T_W][2]);
        o_norm.my   <= unit_val(r_root[T_W][1], r_neg[T_W][1])
                     + unit_val(r_root[T_W][4], r_neg[T_W][3]);
        // The z slope is always -1.
        o_norm.mz   <= unit_val(r_root[T_W][2], 1'b1)
                     + unit_val(r_root[T_W][5], 1'b1);
    end

endmodule

`default_nettype wire

/* src/lhs_shade.sv */
// Dot product with the light vector, rounding, saturation and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module lhs_shade (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lhs_pkg::t_norm                i_norm,
    input  wire logic signed [lhs_pkg::L_W-1:0] i_light_x,
    input  wire logic signed [lhs_pkg::L_W-1:0] i_light_y,
    input  wire logic signed [lhs_pkg::L_W-1:0] i_light_z,
    input  wire logic                          i_claim,
    output logic                               o_slot_free,
    output logic                               o_tvalid,
    input  wire logic                          i_tready,
    output logic [lhs_pkg::H_W-1:0]            o_tdata,
    output logic                               o_tlast
);

    import lhs_pkg::*;

    localparam int P_W   = M_W + L_W;
    localparam int SUM_W = P_W + 2;
    localparam int CW    = FIFO_AW + 1;

    logic signed [P_W-1:0] r_px, r_py, r_pz;
    logic                  r_p_valid, r_p_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_norm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_last <= i_norm.last;
        r_px     <= i_norm.mx * i_light_x;
        r_py     <= i_norm.my * i_light_y;
        r_pz     <= i_norm.mz * i_light_z;
    end

    logic signed [SUM_W-1:0] total, quo;
    logic signed [H_W-1:0]   sat;

    // The arithmetic shift floors, so adding half before it rounds half up.
    always_comb begin
        total = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz) + SUM_W'(16384);
        quo   = total >>> 15;
        if (quo > SUM_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (quo < -SUM_W'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = quo[H_W-1:0];
        end
    end

    // Every accepted pixel holds a queue slot from acceptance until its
    // transaction on the output, so the queue can never overflow.
    logic [H_W:0]         r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]        r_cnt, r_used;
    logic                 pop;

    assign o_tvalid    = (r_cnt != '0);
    assign pop         = o_tvalid && i_tready;
    assign o_tdata     = r_fifo[r_rptr][H_W-1:0];
    assign o_tlast     = r_fifo[r_rptr][H_W];
    assign o_slot_free = (r_used != CW'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_fifo[r_wptr] <= {r_p_last, sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (r_p_valid) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            r_cnt  <= r_cnt + CW'(r_p_valid) - CW'(pop);
            r_used <= r_used + CW'(i_claim) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

/* src/lambert_hillshade.sv */
// Top level of the streaming Lambertian hillshade block.
//
// Height samples enter on the slave stream (tdata = height, tuser = pad flag)
// in scan order, line_length samples to a line, line_count lines, followed by
// one line of pad items. The first line gives no results; each later item,
// pad items included, releases the shade of the pixel one line above it, so
// the results trail the input by one line. tlast marks the final pixel.
// The configuration channel writes light_x, light_y, light_z, line_length and
// line_count at indexes 0 to 4; write it only while the block is idle.
// One item is taken every cycle while a queue slot is free. Most of the depth
// of the path to the output queue is the 15-stage root search.
// The 32-entry output queue reserves a slot for each accepted item that gives
// a result, so input is taken while results wait, and the input stalls only
// once 32 results are in flight or waiting. After reset the counters point to
// the first sample of an image and the light points straight down the z axis.
`timescale 1ns / 1ps
`default_nettype none

module lambert_hillshade #(
    parameter int LINE_MAX = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream. tdata: [15:0] height. tuser: [0] pad.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,
    input  wire logic [0:0]  i_s_tuser,
    // Output stream. tdata: [15:0] shade.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,
    output logic             o_m_tlast,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);

    import lhs_pkg::*;

    localparam logic [2:0] CFG_LIGHT_X = 3'd0;
    localparam logic [2:0] CFG_LIGHT_Y = 3'd1;
    localparam logic [2:0] CFG_LIGHT_Z = 3'd2;
    localparam logic [2:0] CFG_LENGTH  = 3'd3;
    localparam logic [2:0] CFG_COUNT   = 3'd4;

    logic signed [L_W-1:0] r_light_x, r_light_y, r_light_z;
    logic [LEN_CFG_W-1:0]  r_line_length;
    logic [CNT_W-1:0]      r_line_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x     <= '0;
            r_light_y     <= '0;
            r_light_z     <= 16'sd16384;
            r_line_length <= LEN_CFG_W'(1024);
            r_line_count  <= CNT_W'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_LIGHT_X: r_light_x     <= i_cfg_data;
                CFG_LIGHT_Y: r_light_y     <= i_cfg_data;
                CFG_LIGHT_Z: r_light_z     <= i_cfg_data;
                CFG_LENGTH:  r_line_length <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_COUNT:   r_line_count  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic  accept, emit, slot_free;
    t_vec  vec;
    t_norm norm;

    // The pad flag needs no decoding: the scan counters already know the pad line.
    assign o_s_tready = slot_free;
    assign accept     = i_s_tvalid && o_s_tready;

    lhs_window #(
        .LINE_MAX (LINE_MAX)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_height      (i_s_tdata),
        .i_line_length (r_line_length),
        .i_line_count  (r_line_count),
        .o_emit        (emit),
        .o_vec         (vec)
    );

    lhs_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec),
        .o_norm  (norm)
    );

    lhs_shade u_shade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_norm      (norm),
        .i_light_x   (r_light_x),
        .i_light_y   (r_light_y),
        .i_light_z   (r_light_z),
        .i_claim     (accept && emit),
        .o_slot_free (slot_free),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_tdata     (o_m_tdata),
        .o_tlast     (o_m_tlast)
    );

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the streaming Lambertian hillshade block.
`timescale 1ns / 1ps
`default_nettype none

module tb;

    localparam int LINE_MAX   = 1024;
    localparam int REG_LIGHT_X = 0;
    localparam int REG_LIGHT_Y = 1;
    localparam int REG_LIGHT_Z = 2;
    localparam int REG_LINE_LEN = 3;
    localparam int REG_LINE_CNT = 4;
    localparam int NUM_REGS    = 5;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [15:0] shade;
        bit          last;
    } shade_t;

    typedef struct {
        logic [15:0] height;
        bit          pad;
        bit          typed;
        logic [15:0] shade;
        bit          last;
    } row_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [15:0] s_tdata    = '0;
    logic [0:0]  s_tuser    = '0;
    logic        m_tready   = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [2:0]  cfg_addr   = '0;
    logic [15:0] cfg_data   = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [15:0] o_m_tdata;
    wire         o_m_tlast;
    wire         o_cfg_ready;

    lambert_hillshade DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: two stored lines, position counters and registers.
    logic signed [15:0] prev_row [LINE_MAX];
    logic signed [15:0] older_row [LINE_MAX];
    int unsigned        col_pos  = 0;
    int unsigned        row_idx  = 0;
    logic signed [15:0] light_x  = 16'sd0;
    logic signed [15:0] light_y  = 16'sd0;
    logic signed [15:0] light_z  = 16'sd16384;
    logic [10:0]        line_len = 11'd1024;
    logic [12:0]        line_cnt = 13'd1024;

    shade_t shade_q [$];
    int     errors     = 0;
    int     items_sent = 0;
    int     src_idle   = 0;
    int     snk_idle   = 0;
    int     cycles     = 0;
    bit     hold_req   = 1'b0;
    logic   holding    = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root, probe;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // One component of a unit vector in Q1.14, rounded half up in magnitude.
    function automatic longint unit_part(longint v, longint unsigned len_sq);
        longint unsigned mag, r;
        mag = (v < 0) ? -v : v;
        r   = (int_sqrt(((mag * mag) << 30) / len_sq) + 1) >> 1;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    task automatic unit_vec(input longint vx, input longint vy, input longint vz,
                            output longint ux, output longint uy, output longint uz);
        longint unsigned len_sq;
        len_sq = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
        ux = unit_part(vx, len_sq);
        uy = unit_part(vy, len_sq);
        uz = unit_part(vz, len_sq);
    endtask

    function automatic longint clip_diff(longint x);
        if (x > 65535) return 65535;
        if (x < -65535) return -65535;
        return x;
    endfunction

    task automatic predict_shade(input logic signed [15:0] h_in, output bit emit,
                                 output logic [15:0] sh_o, output bit last_o);
        int unsigned len, cnt, p, lo;
        bit flush, rf, rl, lf, ll, done;
        longint ctr, pp, np, a, b, c, d, sum, sh;
        longint x1, y1, z1, x2, y2, z2, mx, my, mz;
        len  = (line_len < 2) ? 2 : ((line_len > LINE_MAX) ? LINE_MAX : line_len);
        cnt  = (line_cnt < 2) ? 2 : line_cnt;
        p    = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        flush = row_idx >= cnt;
        rf   = (p == 0);
        rl   = (p + 1 >= len);
        emit = (row_idx != 0);
        done = 1'b0;
        sh_o = '0;
        if (emit) begin
            lo  = row_idx - 1;
            ctr = prev_row[p];
            pp  = rf ? 0 : older_row[p-1];
            np  = rl ? 0 : prev_row[p+1];
            a   = clip_diff(ctr - h_in);
            b   = clip_diff(ctr - np);
            c   = clip_diff(ctr - older_row[p]);
            d   = clip_diff(ctr - pp);
            lf  = (lo == 0);
            ll  = (lo + 1 >= cnt);
            if (!rf && !rl && !lf && !ll) begin
                unit_vec(-a, b, -1, x1, y1, z1);
                unit_vec(c, -d, -1, x2, y2, z2);
                mx = x1 + x2;
                my = y1 + y2;
                mz = z1 + z2;
            end else begin
                // The two odd corners mix one slope from each side.
                if (rf && ll && !lf) unit_vec(c, b, -1, x1, y1, z1);
                else if (rl && lf && !ll) unit_vec(-a, -d, -1, x1, y1, z1);
                else if (rf || lf) unit_vec(-a, b, -1, x1, y1, z1);
                else unit_vec(c, -d, -1, x1, y1, z1);
                mx = 2 * x1;
                my = 2 * y1;
                mz = 2 * z1;
            end
            sum = mx * light_x + my * light_y + mz * light_z;
            sh  = (sum + 16384) >>> 15;
            if (sh > 32767) sh = 32767;
            if (sh < -32768) sh = -32768;
            sh_o = sh[15:0];
        end
        older_row[p] = prev_row[p];
        prev_row[p]  = h_in;
        if (rl) begin
            col_pos = 0;
            if (flush) begin
                row_idx = 0;
                done    = 1'b1;
            end else begin
                row_idx = (row_idx + 1) & 13'h1FFF;
            end
        end else begin
            col_pos = p + 1;
        end
        last_o = done;
    endtask

    task automatic report_mismatch(input string msg);
        if (errors < 40) $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_result(input logic [15:0] shade, input bit last);
        shade_t exp_r;
        if (shade_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", shade));
        end else begin
            exp_r = shade_q.pop_front();
            if (shade !== exp_r.shade)
                report_mismatch($sformatf("shade %h, expected %h", shade, exp_r.shade));
            if (last !== exp_r.last)
                report_mismatch($sformatf("last %b, expected %b", last, exp_r.last));
        end
    endtask

    // Receiver: checks on the accepting edge, then picks next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tready && o_m_tvalid) check_result(o_m_tdata, o_m_tlast);
        m_tready <= !holding && ($urandom_range(99) >= snk_idle);
    end

    // Long back-pressure stretch so the output queue fills and input stalls.
    initial begin
        wait (hold_req);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input logic [15:0] h, input bit pad, input bit typed,
                             input logic [15:0] t_shade, input bit t_last);
        bit emit, last;
        logic [15:0] sh;
        if ($urandom_range(99) < src_idle) begin
            repeat ($urandom_range(1, 4)) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tuser  <= pad;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        predict_shade(h, emit, sh, last);
        if (emit) begin
            if (typed) shade_q.push_back('{t_shade, t_last});
            else shade_q.push_back('{sh, last});
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (shade_q.size() != 0) @(posedge i_clk);
        // The block may still be finishing work after the last result.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] lx, input logic [15:0] ly,
                              input logic [15:0] lz, input logic [10:0] len,
                              input logic [12:0] cnt);
        logic [15:0] vals [NUM_REGS];
        vals = '{lx, ly, lz, {5'b0, len}, {3'b0, cnt}};
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= i[2:0];
            cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (i)
                REG_LIGHT_X:  light_x  = vals[i];
                REG_LIGHT_Y:  light_y  = vals[i];
                REG_LIGHT_Z:  light_z  = vals[i];
                REG_LINE_LEN: line_len = vals[i][10:0];
                REG_LINE_CNT: line_cnt = vals[i][12:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_light();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    // Sends one whole image of the used size, then its line of pad items.
    task automatic run_image;
        int unsigned len, cnt, style;
        int          walk;
        logic [15:0] h;
        len   = (line_len < 2) ? 2 : ((line_len > LINE_MAX) ? LINE_MAX : line_len);
        cnt   = (line_cnt < 2) ? 2 : line_cnt;
        style = $urandom_range(2);
        walk  = $urandom_range(16'hFFFF) - 32768;
        for (int unsigned n = 0; n < len * cnt; n++) begin
            case (style)
                0: h = $urandom_range(16'hFFFF);
                1: begin
                    walk = walk + $urandom_range(64) - 32;
                    h    = walk[15:0];
                end
                default: h = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
            endcase
            send_item(h, $urandom_range(19) == 0, 1'b0, '0, 1'b0);
        end
        for (int unsigned n = 0; n < len; n++)
            send_item($urandom_range(16'hFFFF), $urandom_range(19) != 0, 1'b0, '0, 1'b0);
    endtask

    row_t flat_rows [6] = '{
        '{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 1'b1, 16'hC000, 1'b0},
        '{16'h0000, 1'b0, 1'b1, 16'hC000, 1'b0},
        '{16'h7FFF, 1'b1, 1'b1, 16'hC000, 1'b0},
        '{16'h8000, 1'b1, 1'b1, 16'hC000, 1'b1}
    };
    logic [15:0] peak_heights [12] = '{
        16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0064,
        16'h8000, 16'h7FFF, 16'h0005, 16'h1234, 16'hABCD, 16'h0000
    };

    initial begin
        for (int i = 0; i < LINE_MAX; i++) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle = 10;
        snk_idle = 70;
        // Flat 2x2 image under the reset light: every pixel faces straight up.
        set_config(16'h0000, 16'h0000, 16'h4000, 11'd2, 13'd2);
        foreach (flat_rows[i])
            send_item(flat_rows[i].height, flat_rows[i].pad, flat_rows[i].typed,
                      flat_rows[i].shade, flat_rows[i].last);
        drain();
        // 3x3 image with extreme heights; pad rows carry heights that must be ignored.
        set_config(16'h2000, 16'hE000, 16'h3000, 11'd3, 13'd3);
        for (int i = 0; i < 9; i++) send_item(peak_heights[i], 1'b0, 1'b0, '0, 1'b0);
        for (int i = 9; i < 12; i++) send_item(peak_heights[i], 1'b1, 1'b0, '0, 1'b0);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            src_idle = (mode == 0) ? 10 : ((mode == 1) ? 70 : 0);
            snk_idle = (mode == 0) ? 70 : ((mode == 1) ? 10 : 0);
            if (mode == 2) begin
                set_config(16'h7FFF, 16'h8000, 16'h8000, 11'd48, 13'd1);
                run_image();
                drain();
                set_config(16'h8000, 16'h7FFF, 16'h7FFF, 11'd40, 13'd2);
                run_image();
                drain();
                set_config(rand_light(), rand_light(), rand_light(), 11'd2, 13'd60);
                hold_req = 1'b1;
                run_image();
                drain();
            end
            while (items_sent < 300 * (mode + 1)) begin
                logic [10:0] len;
                logic [12:0] cnt;
                // Mostly small images; register values below the minimum clamp up.
                len = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
                cnt = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
                set_config(rand_light(), rand_light(), rand_light(), len, cnt);
                repeat ($urandom_range(1, 3)) run_image();
                drain();
            end
        end

        if (errors == 0 && shade_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/lhs_pkg.sv
src/lhs_ram.sv
src/lhs_window.sv
src/lhs_unit.sv
src/lhs_shade.sv
src/lambert_hillshade.sv
dv/tb.sv
